// ===== hdl/wcp_pkg.sv =====
// Shared constants and types for the wall column projection block.
package wcp_pkg;

    localparam int COS_DEPTH_DEF = 256;
    localparam int COS_W         = 16;

    localparam int COL_W   = 12;
    localparam int ANGLE_W = 16;
    localparam int DIST_W  = 16;
    localparam int SIDE_W  = 2;
    localparam int TILE_W  = 8;
    localparam int SH_W    = 12;
    localparam int CW_W    = 16;
    localparam int LEFT_W  = 16;
    localparam int TOP_W   = 16;
    localparam int HGT_W   = 14;
    localparam int CLR_W   = 8;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 88;
    localparam int CFG_W    = 16;

    // height numerator is screen_height * 128
    localparam int HNUM_W = SH_W + 7;

    localparam logic [13:0] QUARTER_OFS = 14'd0;
    localparam logic [11:0] BRT_FULL    = 12'd2560;
    localparam logic [15:0] BRT_SCALE   = 16'd255;
    // floor(z/25) = (z * 5243) >> 17 for z below 6400
    localparam logic [15:0] RCP_25      = 16'd5243;

    localparam logic [3:0] SHADE_NS   = 4'd10;
    localparam logic [3:0] SHADE_EW   = 4'd9;
    localparam logic [3:0] SHADE_S    = 4'd8;

    localparam logic [SIDE_W-1:0] SIDE_NORTH = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_SOUTH = 2'd3;

    localparam logic [TILE_W-1:0] TILE_RED   = 8'd2;
    localparam logic [TILE_W-1:0] TILE_GREEN = 8'd3;
    localparam logic [TILE_W-1:0] TILE_BLUE  = 8'd4;

    typedef enum logic [0:0] {
        REG_SCREEN_HEIGHT = 1'b0,
        REG_COLUMN_WIDTH  = 1'b1
    } cfg_reg_t;

endpackage

// ===== hdl/wcp_cos_rom.sv =====
// Quarter-wave cosine table, Q1.15, built at elaboration, registered read.
module wcp_cos_rom #(
    parameter int COS_TABLE_DEPTH = wcp_pkg::COS_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic [$clog2(COS_TABLE_DEPTH)-1:0] idx,
    output logic [wcp_pkg::COS_W-1:0]          data
);
    import wcp_pkg::*;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam int          ROM_W   = COS_TABLE_DEPTH * COS_W;

    function automatic logic [COS_W-1:0] cos_entry(input int k);
        logic [63:0] theta;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        begin
            theta = (64'(k) * PI_Q30) / (2 * COS_TABLE_DEPTH);
            x2    = (theta * theta) >> 30;
            term  = ONE_Q30;
            sum   = longint'(ONE_Q30);
            for (int i = 1; i <= 12; i++) begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * i - 1) * (2 * i));
                if (i % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (64'(sum) + 64'd16384) >> 15;
            if (v > 64'd32768) begin
                v = 64'd32768;
            end
            cos_entry = v[COS_W-1:0];
        end
    endfunction

    function automatic logic [ROM_W-1:0] build_rom();
        logic [ROM_W-1:0] rom;
        begin
            rom = '0;
            for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
                rom[k*COS_W +: COS_W] = cos_entry(k);
            end
            build_rom = rom;
        end
    endfunction

    localparam logic [ROM_W-1:0] COS_ROM = build_rom();

    logic [COS_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= COS_ROM[idx*COS_W +: COS_W];
    end

    assign data = data_reg;

endmodule

// ===== hdl/wcp_div.sv =====
// Restoring divider, one quotient bit per cycle.
module wcp_div #(
    parameter int NUM_W = wcp_pkg::HNUM_W,
    parameter int DEN_W = wcp_pkg::DIST_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);
    import wcp_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   trial;
    logic             ge;

    always_comb begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy = busy_reg;
    assign quot = quo_reg;

endmodule

// ===== hdl/wall_column_projection.sv =====
// Wall column projection: sequencer around a shared multiplier and divider.
// One ray request is taken when s_tready is high; the block then works on it alone. With a
// positive corrected distance the result is loaded into the output register after these steps:
// cosine read, distance multiply, then a divide for the column height that overlaps the
// brightness and left-edge multiplies, and a final step to finish. s_tready returns after the
// load, so a new request is taken only once the previous one is done. Without a divide the
// steps are the same but for the wait on the divider.
// The result register holds while m_tready is low, and the next request is accepted meanwhile;
// its result then waits until the held one is taken.
// The cosine table is fixed and needs no fill after reset.
module wall_column_projection #(
    parameter int COS_TABLE_DEPTH = wcp_pkg::COS_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  wcp_pkg::cfg_reg_t             cfg_index,
    input  logic [wcp_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // column_index, ray_angle, view_angle, ray_distance, wall_side, tile_value
    input  logic [wcp_pkg::S_DATA_W-1:0]  s_tdata,
    // frame_start
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_column, column_left, column_top, column_height, red, green, blue
    output logic [wcp_pkg::M_DATA_W-1:0]  m_tdata
);
    import wcp_pkg::*;

    localparam int IDX_W = $clog2(COS_TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_COS,
        S_MUL_DIST,
        S_MAG,
        S_MUL_BRT,
        S_MUL_RCP,
        S_MUL_LEFT,
        S_WAIT,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [SH_W-1:0]   sh_reg;
    logic [CW_W-1:0]   cw_reg;
    logic [COL_W-1:0]  col_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [TILE_W-1:0] tile_reg;
    logic              fs_reg;
    logic              neg_reg;
    logic              zero_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [31:0]       prod_reg;
    logic              dcpos_reg;
    logic [14:0]       ms_reg;
    logic [CLR_W-1:0]  level_reg;
    logic [HGT_W-1:0]  held_reg;
    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // input unpack
    logic [COL_W-1:0]   in_col;
    logic [ANGLE_W-1:0] in_ray;
    logic [ANGLE_W-1:0] in_view;
    logic [DIST_W-1:0]  in_dist;
    logic [SIDE_W-1:0]  in_side;
    logic [TILE_W-1:0]  in_tile;

    assign in_col  = s_tdata[11:0];
    assign in_ray  = s_tdata[27:12];
    assign in_view = s_tdata[43:28];
    assign in_dist = s_tdata[59:44];
    assign in_side = s_tdata[61:60];
    assign in_tile = s_tdata[69:62];

    // angle folding into a quarter-wave table index
    logic [ANGLE_W-1:0] ang;
    logic [1:0]         quad;
    logic [13:0]        ofs;
    logic [14:0]        u;
    logic [31:0]        idx_prod;
    logic               ang_zero;
    logic               ang_neg;

    always_comb begin
        ang      = in_ray - in_view;
        quad     = ang[15:14];
        ofs      = ang[13:0];
        u        = quad[0] ? (15'd16384 - {1'b0, ofs}) : {1'b0, ofs};
        ang_zero = quad[0] && (ofs == QUARTER_OFS);
        ang_neg  = quad[1] ^ quad[0];
        idx_prod = 32'(u) * 32'(COS_TABLE_DEPTH);
    end

    logic [COS_W-1:0] cos_data;

    wcp_cos_rom #(
        .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
    ) u_rom (
        .aclk(aclk),
        .idx (idx_reg),
        .data(cos_data)
    );

    // corrected distance and brightness operand
    logic [DIST_W-1:0] mag;
    logic              dcpos;
    logic [11:0]       bm;
    logic [3:0]        shade;
    logic [14:0]       ms;

    always_comb begin
        mag   = prod_reg[30:15];
        dcpos = !neg_reg && (mag != '0);
        if (!dcpos) begin
            bm = BRT_FULL;
        end else if (mag >= DIST_W'(BRT_FULL)) begin
            bm = '0;
        end else begin
            bm = 12'(DIST_W'(BRT_FULL) - mag);
        end
        if (side_reg == SIDE_NORTH) begin
            shade = SHADE_NS;
        end else if (side_reg == SIDE_SOUTH) begin
            shade = SHADE_S;
        end else begin
            shade = SHADE_EW;
        end
        ms = 15'(bm) * 15'(shade);
    end

    logic              div_start;
    logic              div_busy;
    logic [HNUM_W-1:0] div_quot;

    assign div_start = (state_reg == S_MAG) && dcpos;

    wcp_div #(
        .NUM_W(HNUM_W),
        .DEN_W(DIST_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    ({sh_reg, 7'd0}),
        .den    (mag),
        .busy   (div_busy),
        .quot   (div_quot)
    );

    // shared multiplier
    logic [15:0] mul_a;
    logic [15:0] mul_b;

    always_comb begin
        unique case (state_reg)
            S_MUL_DIST: begin
                mul_a = dist_reg;
                mul_b = zero_reg ? '0 : cos_data;
            end
            S_MUL_BRT: begin
                mul_a = 16'(ms_reg);
                mul_b = BRT_SCALE;
            end
            S_MUL_RCP: begin
                mul_a = 16'(prod_reg[22:10]);
                mul_b = RCP_25;
            end
            S_MUL_LEFT: begin
                mul_a = 16'(col_reg);
                mul_b = cw_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // result assembly
    logic [HGT_W-1:0]        hsat;
    logic [HGT_W-1:0]        height;
    logic signed [TOP_W-1:0] diff;
    logic signed [TOP_W-1:0] top;
    logic [LEFT_W-1:0]       left;
    logic                    gray;
    logic [CLR_W-1:0]        red;
    logic [CLR_W-1:0]        green;
    logic [CLR_W-1:0]        blue;

    always_comb begin
        hsat   = (|div_quot[HNUM_W-1:HGT_W]) ? '1 : div_quot[HGT_W-1:0];
        height = dcpos_reg ? hsat : (fs_reg ? '0 : held_reg);
        diff   = signed'(TOP_W'(sh_reg)) - signed'(TOP_W'(height));
        top    = diff >>> 1;
        left   = (|prod_reg[31:24]) ? '1 : prod_reg[23:8];
        gray   = (tile_reg < TILE_RED) || (tile_reg > TILE_BLUE);
        red    = (gray || tile_reg == TILE_RED)   ? level_reg : '0;
        green  = (gray || tile_reg == TILE_GREEN) ? level_reg : '0;
        blue   = (gray || tile_reg == TILE_BLUE)  ? level_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sh_reg <= SH_W'(480);
            cw_reg <= CW_W'(256);
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_SCREEN_HEIGHT: sh_reg <= cfg_wdata[SH_W-1:0];
                REG_COLUMN_WIDTH:  cw_reg <= cfg_wdata[CW_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            held_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_COS;
                    end
                end
                S_COS:      state_reg <= S_MUL_DIST;
                S_MUL_DIST: state_reg <= S_MAG;
                S_MAG:      state_reg <= S_MUL_BRT;
                S_MUL_BRT:  state_reg <= S_MUL_RCP;
                S_MUL_RCP:  state_reg <= S_MUL_LEFT;
                S_MUL_LEFT: state_reg <= S_WAIT;
                S_WAIT: begin
                    if (!div_busy) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        held_reg     <= height;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            col_reg  <= in_col;
            dist_reg <= in_dist;
            side_reg <= in_side;
            tile_reg <= in_tile;
            fs_reg   <= s_tuser;
            neg_reg  <= ang_neg;
            zero_reg <= ang_zero;
            idx_reg  <= idx_prod[14 +: IDX_W];
        end
        if (state_reg == S_MUL_DIST || state_reg == S_MUL_BRT ||
            state_reg == S_MUL_RCP || state_reg == S_MUL_LEFT) begin
            prod_reg <= 32'(mul_a) * 32'(mul_b);
        end
        if (state_reg == S_MAG) begin
            dcpos_reg <= dcpos;
            ms_reg    <= ms;
        end
        if (state_reg == S_MUL_LEFT) begin
            level_reg <= (|prod_reg[31:25]) ? '1 : prod_reg[24:17];
        end
        if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {6'd0, blue, green, red, height, top, left, col_reg};
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/tb_wall_column_projection.sv =====
// Self-checking testbench for wall_column_projection: directed rays, then random phases.
`timescale 1ns / 100ps

module tb_wall_column_projection;
    import wcp_pkg::*;

    localparam int PHASES     = 8;
    localparam int PHASE_RAYS = 216;
    localparam int COS_DEPTH  = 256;
    localparam int HEIGHT_MAX = 16383;

    typedef struct packed {
        logic        fstart;
        logic [7:0]  tile;
        logic [1:0]  side;
        logic [15:0] distance;
        logic [15:0] view;
        logic [15:0] ray;
        logic [11:0] col;
    } ray_t;

    typedef struct packed {
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
        logic [13:0]        height;
        logic signed [15:0] top;
        logic [15:0]        left;
        logic [11:0]        column;
    } col_t;

    typedef struct {
        ray_t req;
        bit   fixed;
        col_t res;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wen = 1'b0;
    cfg_reg_t            cfg_index = REG_SCREEN_HEIGHT;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    logic [15:0]  cos_rom [COS_DEPTH];
    int unsigned  held_hgt;
    int unsigned  cur_sh;
    int unsigned  cur_cw;
    col_t         expected_cols [$];
    dir_row_t     dir_rows [$];
    int           errors = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;

    wall_column_projection u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Q1.15 cosine from a truncated Taylor series in Q30
    function automatic logic [15:0] cos_q15(longint unsigned k);
        longint unsigned theta, x2, term, v;
        longint          sum;
        theta = (k * 64'd3373259426) / (2 * COS_DEPTH);
        x2 = (theta * theta) >> 30;
        term = 64'd1 << 30;
        sum = longint'(term);
        for (int i = 1; i <= 12; i++) begin
            term = (term * x2) >> 30;
            term = term / ((2 * i - 1) * (2 * i));
            if (i % 2)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (sum + 64'd16384) >> 15;
        if (v > 32768)
            v = 32768;
        return v[15:0];
    endfunction

    function automatic col_t project_column(ray_t r);
        logic [15:0]     a;
        logic [1:0]      quad;
        int unsigned     u, idx, h, shade;
        longint unsigned c, mag, lft, d64, col64, lvl;
        logic            neg, gray;
        int              dc, diff;
        longint          n;
        col_t            res;
        if (r.fstart)
            held_hgt = 0;
        a = r.ray - r.view;
        quad = a[15:14];
        u = (quad == 2'd0 || quad == 2'd2) ? a[13:0] : 16384 - a[13:0];
        idx = u * COS_DEPTH / 16384;
        c = (idx >= COS_DEPTH) ? 0 : cos_rom[idx];
        neg = (quad == 2'd1 || quad == 2'd2);
        d64 = r.distance;
        mag = (d64 * c) >> 15;
        dc = neg ? -int'(mag) : int'(mag);
        if (dc > 0) begin
            h = (128 * cur_sh) / unsigned'(dc);
            held_hgt = (h > HEIGHT_MAX) ? HEIGHT_MAX : h;
        end
        diff = int'(cur_sh) - int'(held_hgt);
        col64 = r.col;
        lft = (col64 * cur_cw) >> 8;
        n = 255 * (2560 - longint'(dc));
        if (n < 0)
            n = 0;
        if (n > 255 * 2560)
            n = 255 * 2560;
        shade = (r.side == SIDE_NORTH) ? SHADE_NS : (r.side == SIDE_SOUTH) ? SHADE_S : SHADE_EW;
        lvl = (n * shade) / 25600;
        if (lvl > 255)
            lvl = 255;
        gray = (r.tile < TILE_RED) || (r.tile > TILE_BLUE);
        res.column = r.col;
        res.left = (lft > 16'hFFFF) ? 16'hFFFF : lft[15:0];
        res.top = 16'(diff >>> 1);
        res.height = held_hgt[13:0];
        res.red = (gray || r.tile == TILE_RED) ? lvl[7:0] : 8'd0;
        res.green = (gray || r.tile == TILE_GREEN) ? lvl[7:0] : 8'd0;
        res.blue = (gray || r.tile == TILE_BLUE) ? lvl[7:0] : 8'd0;
        return res;
    endfunction

    function automatic ray_t mk_ray(int col, int ray, int view, int distance, int side, int tile,
                                    int fs);
        ray_t r;
        r.col = 12'(col);
        r.ray = 16'(ray);
        r.view = 16'(view);
        r.distance = 16'(distance);
        r.side = 2'(side);
        r.tile = 8'(tile);
        r.fstart = 1'(fs);
        return r;
    endfunction

    // mostly near-forward rays at plausible distances, some fully random
    function automatic ray_t random_ray();
        ray_t r;
        int   sel;
        r.col = 12'($urandom_range(0, 4095));
        r.view = 16'($urandom);
        if ($urandom_range(0, 9) < 7)
            r.ray = r.view + 16'($urandom_range(0, 24000) - 12000);
        else
            r.ray = 16'($urandom);
        sel = $urandom_range(0, 9);
        if (sel == 0)
            r.distance = 16'd0;
        else if (sel <= 5)
            r.distance = 16'($urandom_range(1, 3000));
        else if (sel <= 7)
            r.distance = 16'($urandom_range(1, 255));
        else
            r.distance = 16'($urandom);
        r.side = 2'($urandom);
        r.tile = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        r.fstart = ($urandom_range(0, 19) == 0);
        return r;
    endfunction

    task automatic report_error(string msg);
        errors++;
        if (errors <= 200)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want)
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge aclk) begin : result_mon
        col_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(col_t)-1:0];
            if (expected_cols.size() == 0) begin
                report_error($sformatf("unexpected column %0d", got.column));
            end else begin
                want = expected_cols.pop_front();
                check_field("out_column", got.column, want.column);
                check_field("column_left", got.left, want.left);
                check_field("column_top", got.top, want.top);
                check_field("column_height", got.height, want.height);
                check_field("red", got.red, want.red);
                check_field("green", got.green, want.green);
                check_field("blue", got.blue, want.blue);
            end
        end
    end

    task automatic send_ray(ray_t r, bit fixed, col_t fixed_res);
        int   gap;
        col_t pred;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, r.tile, r.side, r.distance, r.view, r.ray, r.col};
        s_tuser <= r.fstart;
        do @(posedge aclk); while (!s_tready);
        pred = project_column(r);
        expected_cols.push_back(fixed ? fixed_res : pred);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_cols.size() != 0);
    endtask

    task automatic write_cfg(int unsigned sh, int unsigned cw);
        cfg_wen <= 1'b1;
        cfg_index <= REG_SCREEN_HEIGHT;
        cfg_wdata <= 16'(sh);
        @(posedge aclk);
        cfg_index <= REG_COLUMN_WIDTH;
        cfg_wdata <= 16'(cw);
        @(posedge aclk);
        cfg_wen <= 1'b0;
        cur_sh = sh & 12'hFFF;
        cur_cw = cw & 16'hFFFF;
    endtask

    initial begin
        int unsigned sh, cw;
        for (int k = 0; k < COS_DEPTH; k++)
            cos_rom[k] = cos_q15(k);
        held_hgt = 0;
        cur_sh = 480;
        cur_cw = 256;

        // forward ray at one tile, after reset
        dir_rows.push_back('{mk_ray(0, 0, 0, 256, 0, 0, 0), 1'b1,
            '{column: 0, left: 0, top: 120, height: 240, red: 229, green: 229, blue: 229}});
        // frame start with zero distance: held height cleared
        dir_rows.push_back('{mk_ray(4095, 0, 0, 0, 0, 2, 1), 1'b1,
            '{column: 4095, left: 4095, top: 240, height: 0, red: 255, green: 0, blue: 0}});
        // smallest distance saturates the height
        dir_rows.push_back('{mk_ray(5, 0, 0, 1, 3, 4, 0), 1'b1,
            '{column: 5, left: 5, top: -7952, height: 16383, red: 0, green: 0, blue: 203}});
        dir_rows.push_back('{mk_ray(1, 100, 100, 65535, 1, 3, 0), 1'b0, '0});
        dir_rows.push_back('{mk_ray(2, 16484, 0, 1000, 2, 2, 0), 1'b0, '0});
        dir_rows.push_back('{mk_ray(3, 32768, 0, 500, 0, 4, 0), 1'b0, '0});
        dir_rows.push_back('{mk_ray(4, 49157, 0, 700, 3, 1, 0), 1'b0, '0});
        dir_rows.push_back('{mk_ray(6, 16384, 0, 900, 1, 5, 0), 1'b0, '0});
        dir_rows.push_back('{mk_ray(7, 0, 65535, 300, 2, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_ray(8, 65535, 0, 2560, 0, 255, 0), 1'b0, '0});
        dir_rows.push_back('{mk_ray(9, 8000, 0, 2000, 2, 255, 1), 1'b0, '0});
        dir_rows.push_back('{mk_ray(10, 32768, 0, 65535, 1, 3, 1), 1'b0, '0});
        dir_rows.push_back('{mk_ray(11, 40000, 100, 123, 0, 2, 0), 1'b0, '0});
        dir_rows.push_back('{mk_ray(12, 1000, 0, 5000, 3, 128, 0), 1'b0, '0});
        dir_rows.push_back('{mk_ray(4095, 65535, 65535, 65535, 3, 255, 1), 1'b0, '0});
        dir_rows.push_back('{mk_ray(0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_ray(2730, 21845, 43690, 43690, 2, 170, 0), 1'b0, '0});
        dir_rows.push_back('{mk_ray(1365, 43690, 21845, 21845, 1, 85, 0), 1'b0, '0});

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_ray(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].res);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            repeat (30) @(posedge aclk);
            case (p)
                0: begin sh = 480;  cw = 256;   end
                1: begin sh = 4095; cw = 65535; end
                2: begin sh = 1;    cw = 1;     end
                3: begin sh = 0;    cw = 0;     end
                5: begin sh = 4095; cw = 1;     end
                6: begin sh = 1;    cw = 65535; end
                default: begin
                    sh = $urandom_range(1, 4095);
                    cw = $urandom_range(1, 65535);
                end
            endcase
            write_cfg(sh, cw);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            for (int i = 0; i < PHASE_RAYS; i++) begin
                if ($urandom_range(0, 99) == 0)
                    drain();
                send_ray(random_ray(), 1'b0, '0);
            end
        end

        drain();
        repeat (60) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
